### design/tsrr_pkg.sv
// ----------------------------------------------------------------------------
// tsrr_pkg
// Shared types and constants for the thread slot round-robin scheduler.
// ----------------------------------------------------------------------------
package tsrr_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int CMD_W          = 3;
  localparam int TAG_W          = 16;
  localparam int HANDLE_W       = 5;

  localparam logic [CMD_W-1:0] CMD_SCHEDULE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOOKUP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FINISH   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED,
    ST_ADD,
    ST_REMOVE,
    ST_DRAIN,
    ST_HANDLE,
    ST_READ,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic sched_step;
    logic add_step;
    logic rm_issue;
    logic hnd_step;
    logic rd_capture;
  } ctrl_t;

  typedef struct packed {
    logic sched_hit;
    logic add_free;
    logic hnd_read;
    logic scan_last;
    logic add_last;
  } stat_t;

endpackage

### design/tsrr_ctrl.sv
// ----------------------------------------------------------------------------
// tsrr_ctrl
// Command sequencer: walks each command through its scan, read and result
// phases and handles both handshakes.
// ----------------------------------------------------------------------------
module tsrr_ctrl #(
  parameter int SLOT_COUNT = tsrr_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [tsrr_pkg::CMD_W-1:0]  in_command,
  output logic                        in_stall,
  output logic                        out_valid,
  input  logic                        out_stall,
  input  tsrr_pkg::stat_t             stat,
  output tsrr_pkg::ctrl_t             ctrl
);

  tsrr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsrr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsrr_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_command)
            tsrr_pkg::CMD_SCHEDULE: state_nxt = tsrr_pkg::ST_SCHED;
            tsrr_pkg::CMD_ADD:
              state_nxt = (SLOT_COUNT > 1) ? tsrr_pkg::ST_ADD : tsrr_pkg::ST_RESULT;
            tsrr_pkg::CMD_REMOVE:   state_nxt = tsrr_pkg::ST_REMOVE;
            tsrr_pkg::CMD_LOOKUP,
            tsrr_pkg::CMD_FINISH:   state_nxt = tsrr_pkg::ST_HANDLE;
            default:                state_nxt = tsrr_pkg::ST_RESULT;
          endcase
        end
      end
      tsrr_pkg::ST_SCHED: begin
        if (stat.sched_hit) begin
          state_nxt = tsrr_pkg::ST_READ;
        end else if (stat.scan_last) begin
          state_nxt = tsrr_pkg::ST_RESULT;
        end
      end
      tsrr_pkg::ST_ADD: begin
        if (stat.add_free || stat.add_last) begin
          state_nxt = tsrr_pkg::ST_RESULT;
        end
      end
      tsrr_pkg::ST_REMOVE: begin
        if (stat.scan_last) begin
          state_nxt = tsrr_pkg::ST_DRAIN;
        end
      end
      tsrr_pkg::ST_DRAIN:  state_nxt = tsrr_pkg::ST_RESULT;
      tsrr_pkg::ST_HANDLE: begin
        state_nxt = stat.hnd_read ? tsrr_pkg::ST_READ : tsrr_pkg::ST_RESULT;
      end
      tsrr_pkg::ST_READ:   state_nxt = tsrr_pkg::ST_RESULT;
      tsrr_pkg::ST_RESULT: begin
        if (!out_stall) begin
          state_nxt = tsrr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tsrr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl            = '0;
    ctrl.load       = (state_r == tsrr_pkg::ST_IDLE) && in_valid && rst_n;
    ctrl.sched_step = (state_r == tsrr_pkg::ST_SCHED);
    ctrl.add_step   = (state_r == tsrr_pkg::ST_ADD);
    ctrl.rm_issue   = (state_r == tsrr_pkg::ST_REMOVE);
    ctrl.hnd_step   = (state_r == tsrr_pkg::ST_HANDLE);
    ctrl.rd_capture = (state_r == tsrr_pkg::ST_READ);
    in_stall        = !rst_n || (state_r != tsrr_pkg::ST_IDLE);
    out_valid       = (state_r == tsrr_pkg::ST_RESULT);
  end

endmodule

### design/tsrr_dpath.sv
// ----------------------------------------------------------------------------
// tsrr_dpath
// Slot table datapath: occupied and alive marks, tag memory, scan index,
// current slot and result registers.
// ----------------------------------------------------------------------------
module tsrr_dpath #(
  parameter int SLOT_COUNT = tsrr_pkg::SLOT_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tsrr_pkg::ctrl_t                ctrl,
  output tsrr_pkg::stat_t                stat,
  input  logic [tsrr_pkg::CMD_W-1:0]     in_command,
  input  logic [tsrr_pkg::TAG_W-1:0]     in_thread_tag,
  input  logic [tsrr_pkg::HANDLE_W-1:0]  in_slot_handle,
  output logic                           res_ok,
  output logic [tsrr_pkg::HANDLE_W-1:0]  res_handle,
  output logic [tsrr_pkg::TAG_W-1:0]     res_tag
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int HW = tsrr_pkg::HANDLE_W;
  localparam int TW = tsrr_pkg::TAG_W;
  localparam logic [CW-1:0] SCAN_LAST = CW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] ADD_LAST  = CW'((SLOT_COUNT > 1) ? SLOT_COUNT - 2 : 0);
  localparam logic [IW-1:0] IDX_MAX   = IW'(SLOT_COUNT - 1);

  function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i);
    return (i == IDX_MAX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i);
    return (i == '0) ? IDX_MAX : i - 1'b1;
  endfunction

  logic [TW-1:0]                tag_mem [SLOT_COUNT];
  logic [TW-1:0]                rd_r;
  logic [SLOT_COUNT-1:0]        used_r, used_nxt;
  logic [SLOT_COUNT-1:0]        alive_r, alive_nxt;
  logic [IW-1:0]                cur_r, cur_nxt;
  logic [IW-1:0]                idx_r, idx_nxt;
  logic [IW-1:0]                pidx_r, pidx_nxt;
  logic                         pv_r, pv_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [tsrr_pkg::CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [TW-1:0]                tag_r, tag_nxt;
  logic [HW-1:0]                hnd_r, hnd_nxt;
  logic                         hv_r, hv_nxt;
  logic                         ok_r, ok_nxt;
  logic [HW-1:0]                oh_r, oh_nxt;
  logic [TW-1:0]                ot_r, ot_nxt;
  logic                         in_hv;
  logic [IW-1:0]                in_hidx;
  logic                         u_cur, a_cur;
  logic                         we;

  assign in_hv   = (in_slot_handle != '0) && (32'(in_slot_handle) <= SLOT_COUNT);
  assign in_hidx = IW'(32'(in_slot_handle) - 32'd1);
  assign u_cur   = used_r[idx_r];
  assign a_cur   = alive_r[idx_r];

  always_comb begin
    stat           = '0;
    stat.sched_hit = u_cur && a_cur;
    stat.add_free  = !u_cur;
    stat.hnd_read  = hv_r && u_cur && (cmd_r == tsrr_pkg::CMD_LOOKUP);
    stat.scan_last = (cnt_r == SCAN_LAST);
    stat.add_last  = (cnt_r == ADD_LAST);
  end

  always_comb begin
    used_nxt  = used_r;
    alive_nxt = alive_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    pidx_nxt  = pidx_r;
    pv_nxt    = ctrl.rm_issue;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    tag_nxt   = tag_r;
    hnd_nxt   = hnd_r;
    hv_nxt    = hv_r;
    ok_nxt    = ok_r;
    oh_nxt    = oh_r;
    ot_nxt    = ot_r;
    we        = 1'b0;

    if (ctrl.load) begin
      cmd_nxt = in_command;
      tag_nxt = in_thread_tag;
      hnd_nxt = in_slot_handle;
      hv_nxt  = in_hv;
      cnt_nxt = '0;
      ok_nxt  = 1'b0;
      oh_nxt  = '0;
      ot_nxt  = '0;
      case (in_command)
        tsrr_pkg::CMD_SCHEDULE: idx_nxt = idx_next(cur_r);
        tsrr_pkg::CMD_ADD:      idx_nxt = idx_prev(cur_r);
        tsrr_pkg::CMD_LOOKUP,
        tsrr_pkg::CMD_FINISH:   idx_nxt = in_hv ? in_hidx : '0;
        default:                idx_nxt = '0;
      endcase
    end

    if (ctrl.sched_step) begin
      if (u_cur && a_cur) begin
        cur_nxt = idx_r;
        ok_nxt  = 1'b1;
        oh_nxt  = HW'(32'(idx_r) + 32'd1);
      end else begin
        if (u_cur) begin
          used_nxt[idx_r]  = 1'b0;
          alive_nxt[idx_r] = 1'b0;
        end
        idx_nxt = idx_next(idx_r);
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    if (ctrl.add_step) begin
      if (!u_cur) begin
        used_nxt[idx_r]  = 1'b1;
        alive_nxt[idx_r] = 1'b1;
        we               = 1'b1;
        ok_nxt           = 1'b1;
        oh_nxt           = HW'(32'(idx_r) + 32'd1);
      end else begin
        idx_nxt = idx_prev(idx_r);
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    if (ctrl.rm_issue) begin
      pidx_nxt = idx_r;
      idx_nxt  = idx_next(idx_r);
      cnt_nxt  = cnt_r + 1'b1;
    end

    // compare the word read in the previous cycle
    if (pv_r && used_r[pidx_r] && (rd_r == tag_r)) begin
      used_nxt[pidx_r]  = 1'b0;
      alive_nxt[pidx_r] = 1'b0;
      ok_nxt            = 1'b1;
    end

    if (ctrl.hnd_step && hv_r && u_cur) begin
      ok_nxt = 1'b1;
      oh_nxt = hnd_r;
      if (cmd_r == tsrr_pkg::CMD_FINISH) begin
        alive_nxt[idx_r] = 1'b0;
      end
    end

    if (ctrl.rd_capture) begin
      ot_nxt = rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      alive_r <= '0;
      cur_r   <= '0;
      pv_r    <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      alive_r <= alive_nxt;
      cur_r   <= cur_nxt;
      pv_r    <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
    cnt_r  <= cnt_nxt;
    cmd_r  <= cmd_nxt;
    tag_r  <= tag_nxt;
    hnd_r  <= hnd_nxt;
    hv_r   <= hv_nxt;
    ok_r   <= ok_nxt;
    oh_r   <= oh_nxt;
    ot_r   <= ot_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tag_mem[idx_r] <= tag_r;
    end
    rd_r <= tag_mem[idx_r];
  end

  assign res_ok     = ok_r;
  assign res_handle = oh_r;
  assign res_tag    = ot_r;

endmodule

### design/thread_slot_round_robin_top.sv
// ----------------------------------------------------------------------------
// thread_slot_round_robin_top
// Round-robin scheduler over a table of thread slots.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes one command word: schedule, add,
// remove by tag, lookup by handle or finish. Result channel (out_valid /
// out_stall) returns exactly one word per command: ok, handle and tag.
// One command is in flight at a time; in_stall is high during reset and from
// the cycle after acceptance until the cycle after its result word is taken,
// so the block takes no new command before the last result word is taken.
// Steps from acceptance to the result word, one slot tested per cycle:
//   schedule: scan forward from the slot after the current one, freeing
//             finished slots, to the first live slot if any; then read its tag
//   add:      scan back from the slot before the current one over the other
//             slots to a free one if any, and claim it
//   remove:   every slot through the single-port tag memory read port
//             plus one compare stage
//   lookup:   handle check, then a tag memory read on an occupied slot
//   finish:   handle check only, also for an unknown handle
// Reset (rst_n low, synchronous) empties every slot and sets the current
// slot to zero; tag memory contents are not cleared. While the receiver
// holds out_stall the result word stays stable and no command is accepted.
// ----------------------------------------------------------------------------
module thread_slot_round_robin_top #(
  parameter int SLOT_COUNT = tsrr_pkg::SLOT_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tsrr_pkg::CMD_W-1:0]     in_command,
  input  logic [tsrr_pkg::TAG_W-1:0]     in_thread_tag,
  input  logic [tsrr_pkg::HANDLE_W-1:0]  in_slot_handle,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_ok,
  output logic [tsrr_pkg::HANDLE_W-1:0]  out_handle,
  output logic [tsrr_pkg::TAG_W-1:0]     out_tag
);

  tsrr_pkg::ctrl_t ctrl;
  tsrr_pkg::stat_t stat;

  tsrr_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  tsrr_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .in_command     (in_command),
    .in_thread_tag  (in_thread_tag),
    .in_slot_handle (in_slot_handle),
    .res_ok         (out_ok),
    .res_handle     (out_handle),
    .res_tag        (out_tag)
  );

endmodule
